// ===== sv/scla_pkg.sv =====
// scla_pkg: sizes and character codes for the serial console line assembler
// no dependencies; imported by serial_console_line_assembler_top
package scla_pkg;

  // line store size in bytes, one slot kept free so the line holds size - 1 chars
  localparam int unsigned LINE_BUFFER_BYTES = 64;
  localparam int unsigned LEN_W             = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LINE_MAX_CHARS = LEN_W'(LINE_BUFFER_BYTES - 1);

  // console character codes
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_LOW  = 8'h20;
  localparam logic [7:0] CH_HIGH = 8'h7E;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // result kinds
  localparam logic EV_LINE_CHAR = 1'b0;
  localparam logic EV_TOO_LONG  = 1'b1;

endpackage

// ===== sv/scla_ram.sv =====
// scla_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for the line store
module scla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/serial_console_line_assembler_top.sv =====
// serial_console_line_assembler_top: builds a console command line and streams it out
// depends on scla_pkg and scla_ram
//
//  channel | direction | ports                                         | handshake
//  in      | input     | in_rx_byte                                    | in_valid / in_ready
//  out     | output    | out_event_kind, out_line_char, out_last       | out_valid / out_ready
//
// printable, backspace, del and ignored bytes are taken back to back while idle
// a terminator on a non-empty line streams its chars out: one store read and one
// output step per char, sequenced over the single ram read port
// a too-long request gives one final result; in_ready is low until the last result is taken
// rst_n (synchronous) empties the line; the store itself is not cleared
// a stall on out_ready holds the current result and the sequencer
module serial_console_line_assembler_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_event_kind,
  output logic [7:0] out_line_char,
  output logic       out_last
);
  import scla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_SEND
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] end_r, end_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             kind_r, kind_nxt;
  logic             last_r, last_nxt;

  logic             in_acc;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // line store
  scla_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BUFFER_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // byte decode and output sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_rx_byte) inside
            CH_CR, CH_LF: begin
              if (len_r != '0) begin
                idx_nxt   = '0;
                end_nxt   = len_r - 1'b1;
                len_nxt   = '0;
                kind_nxt  = EV_LINE_CHAR;
                state_nxt = S_FETCH;
              end
            end
            CH_BS, CH_DEL: begin
              if (len_r != '0) begin
                len_nxt = len_r - 1'b1;
              end
            end
            [CH_LOW:CH_HIGH]: begin
              if (len_r < LINE_MAX_CHARS) begin
                ram_we  = 1'b1;
                len_nxt = len_r + 1'b1;
              end else begin
                // full line: discard it and report
                len_nxt       = '0;
                kind_nxt      = EV_TOO_LONG;
                last_nxt      = 1'b1;
                out_valid_nxt = 1'b1;
                state_nxt     = S_SEND;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        // read one stored char, compare against the final index
        ram_re        = 1'b1;
        last_nxt      = (idx_r == end_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_last       = last_r;
  assign out_line_char  = (kind_r == EV_TOO_LONG) ? 8'h00 : ram_rdata;

`ifndef SYNTHESIS
  // no new byte is taken while a result is pending
  a_no_accept_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // a too-long event is a single final result with a zero char
  a_too_long_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind) |-> (out_last && (out_line_char == 8'h00)))
    else $error("malformed too-long result");

  // taking the final result returns the block to accepting bytes
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("block not ready after final result");

  // a terminator on a non-empty line empties the line
  a_term_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ((in_rx_byte == CH_CR) || (in_rx_byte == CH_LF)))
      |=> (len_r == '0))
    else $error("line not cleared by terminator");
`endif

endmodule
